/* rtl/battery_cycle_charge_controller_defines.svh */
// assertion macros used by the checker file
`ifndef BATTERY_CYCLE_CHARGE_CONTROLLER_DEFINES_SVH
`define BATTERY_CYCLE_CHARGE_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BCCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BCCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/bccc_pkg.sv */
package bccc_pkg;

    // field widths
    localparam int MV_W     = 16;
    localparam int MA_W     = 14;
    localparam int TARGET_W = 13;
    localparam int BAND_W   = 10;
    localparam int CUTOFF_W = 13;
    localparam int OUT_STEP_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // regulator step range
    localparam int STEP_MAX = 1023;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);

    // preset: trunc((17*mv - OFFSET) * STEP_MAX / SPAN), saturated
    localparam int PRESET_OFFSET = 33600;
    localparam int PRESET_SPAN   = 40000;
    localparam int PRESET_SHIFT  = 6;
    localparam int PRESET_DIV    = PRESET_SPAN / (2 ** PRESET_SHIFT);
    localparam int RECIP_SHIFT   = 30;
    localparam longint RECIP_MUL =
        ((64'(1) << RECIP_SHIFT) + PRESET_DIV - 1) / PRESET_DIV;
    localparam int RECIP_W       = 21;
    localparam int MV17_W        = MV_W + 5;

    // signed compare width for current limits
    localparam int LIM_W = MA_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd4;

    // register reset values
    localparam logic [TARGET_W-1:0] TARGET_RST = 13'd350;
    localparam logic [BAND_W-1:0]   BAND_RST   = 10'd5;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 13'd50;
    localparam logic [MV_W-1:0]     LIMIT_RST  = 16'd4100;
    localparam logic [MV_W-1:0]     FLOOR_RST  = 16'd3050;

    // cycle modes
    localparam logic MODE_CHARGE = 1'b0;
    localparam logic MODE_DRAIN  = 1'b1;

    typedef struct packed {
        logic [MV_W-1:0]        mv;
        logic signed [MA_W-1:0] ma;
    } sample_t;

    typedef struct packed {
        logic [OUT_STEP_W-1:0] step;
        logic                  charge_en;
        logic                  drain_en;
        logic                  mode;
        logic                  switched;
    } result_t;

endpackage

/* rtl/bccc_if.sv */
// sample channel: one voltage and current reading per beat
interface bccc_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic [bccc_pkg::MV_W-1:0]             battery_mv;
    logic signed [bccc_pkg::MA_W-1:0]      battery_ma;

    modport source (output valid, output battery_mv, output battery_ma, input ready);
    modport sink   (input valid, input battery_mv, input battery_ma, output ready);
endinterface

// result channel: regulator step and mode flags per beat
interface bccc_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [bccc_pkg::OUT_STEP_W-1:0]       regulator_step;
    logic                                  charge_enable;
    logic                                  drain_enable;
    logic                                  cycle_mode;
    logic                                  mode_switched;

    modport source (output valid, output regulator_step, output charge_enable,
                    output drain_enable, output cycle_mode, output mode_switched,
                    input ready);
    modport sink   (input valid, input regulator_step, input charge_enable,
                    input drain_enable, input cycle_mode, input mode_switched,
                    output ready);
endinterface

/* rtl/bccc_preset.sv */
module bccc_preset (
    input  logic [bccc_pkg::MV_W-1:0]   mv,
    output logic [bccc_pkg::STEP_W-1:0] step
);
    import bccc_pkg::*;

    localparam int PROD_W = 16 + STEP_W;
    localparam int X_W    = PROD_W - PRESET_SHIFT;
    localparam int Q_W    = X_W + RECIP_W;

    logic [MV17_W-1:0] mv17;
    logic [MV17_W-1:0] num;
    logic              above;
    logic              sat;
    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]    x;
    logic [Q_W-1:0]    q;

    // 17*mv less the offset; nothing positive means step zero
    assign mv17  = {mv, 4'b0000} + MV17_W'(mv);
    assign above = mv17 > MV17_W'(PRESET_OFFSET);
    assign num   = mv17 - MV17_W'(PRESET_OFFSET);
    assign sat   = num >= MV17_W'(PRESET_SPAN);

    // scale by step max, then divide by span as a shift and a reciprocal multiply
    assign prod = PROD_W'(num[15:0]) * PROD_W'(STEP_MAX);
    assign x    = prod[PROD_W-1:PRESET_SHIFT];
    assign q    = Q_W'(x) * Q_W'(RECIP_MUL);

    always_comb
    begin
        if (!above)
            step = '0;
        else if (sat)
            step = STEP_W'(STEP_MAX);
        else
            step = q[RECIP_SHIFT +: STEP_W];
    end

endmodule

/* rtl/battery_cycle_charge_controller.sv */
// channel   | dir | beat carries
// sample    | in  | battery_mv, battery_ma
// result    | out | regulator_step, charge_enable, drain_enable, cycle_mode, mode_switched
// cfg_*     | in  | register index and write data, write on cfg_wr_en
//
// one beat in per clock unless results stall; sample -> input register -> result register
// the mode and step update for a sample is combinational, between the
// input register and the result register, so each sample sees the previous one's state
// result register stalls hold the input register; sample ready drops only when both are full
// reset: drain mode, step zero, registers at their defaults, both channels empty
module battery_cycle_charge_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    bccc_sample_if.sink                       sample,
    bccc_result_if.source                     result,
    input  logic                              cfg_wr_en,
    input  logic [bccc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bccc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import bccc_pkg::*;

    logic [TARGET_W-1:0] target_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [MV_W-1:0]     limit_reg;
    logic [MV_W-1:0]     floor_reg;

    logic                in_valid_reg;
    sample_t             in_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             out_next;

    logic                mode_reg;
    logic                mode_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [STEP_W-1:0]   preset;

    logic                advance;
    logic signed [LIM_W-1:0] lo;
    logic signed [LIM_W-1:0] hi;
    logic signed [LIM_W-1:0] ma_ext;
    logic                nudge_up;
    logic                nudge_dn;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            band_reg   <= BAND_RST;
            cutoff_reg <= CUTOFF_RST;
            limit_reg  <= LIMIT_RST;
            floor_reg  <= FLOOR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TARGET: target_reg <= cfg_wdata[TARGET_W-1:0];
                REG_BAND:   band_reg   <= cfg_wdata[BAND_W-1:0];
                REG_CUTOFF: cutoff_reg <= cfg_wdata[CUTOFF_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_wdata[MV_W-1:0];
                REG_FLOOR:  floor_reg  <= cfg_wdata[MV_W-1:0];
                default:    ;
            endcase
        end
    end

    // handshake: the input register moves on whenever the result register frees
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_reg.mv <= sample.battery_mv;
            in_reg.ma <= sample.battery_ma;
        end
    end

    bccc_preset u_preset (
        .mv   (in_reg.mv),
        .step (preset)
    );

    // dead band around the target current
    assign ma_ext   = LIM_W'(in_reg.ma);
    assign lo       = $signed(LIM_W'(target_reg)) - $signed(LIM_W'(band_reg));
    assign hi       = $signed(LIM_W'(target_reg)) + $signed(LIM_W'(band_reg));
    assign nudge_up = ma_ext <= lo;
    assign nudge_dn = ma_ext >= hi;

    // mode and step update for the sample in the input register
    always_comb
    begin
        mode_next = mode_reg;
        step_next = step_reg;
        if (mode_reg == MODE_CHARGE)
        begin
            if (in_reg.mv < limit_reg)
            begin
                if (nudge_up && !nudge_dn && step_reg != STEP_W'(STEP_MAX))
                    step_next = step_reg + 1'b1;
                else if (nudge_dn && !nudge_up && step_reg != '0)
                    step_next = step_reg - 1'b1;
            end
            else if (ma_ext <= $signed(LIM_W'(cutoff_reg)))
                mode_next = MODE_DRAIN;
        end
        else if (in_reg.mv <= floor_reg)
        begin
            step_next = preset;
            mode_next = MODE_CHARGE;
        end
    end

    always_comb
    begin
        out_next.step      = OUT_STEP_W'(step_next);
        out_next.charge_en = mode_next == MODE_CHARGE;
        out_next.drain_en  = mode_next == MODE_DRAIN;
        out_next.mode      = mode_next;
        out_next.switched  = mode_next != mode_reg;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DRAIN;
            step_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            step_reg <= step_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.regulator_step = out_reg.step;
    assign result.charge_enable  = out_reg.charge_en;
    assign result.drain_enable   = out_reg.drain_en;
    assign result.cycle_mode     = out_reg.mode;
    assign result.mode_switched  = out_reg.switched;

endmodule

/* rtl/bccc_checker.sv */
`include "battery_cycle_charge_controller_defines.svh"

module bccc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [bccc_pkg::OUT_STEP_W-1:0]   out_step,
    input logic                              out_charge,
    input logic                              out_drain,
    input logic                              out_mode
);
    import bccc_pkg::*;

    // a stalled result beat keeps its payload
    `BCCC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_step) && $stable(out_mode))

    // exactly one of charger and drain load connected
    `BCCC_ASSERT_NOW(a_enable_excl, out_valid, out_charge != out_drain)

    // the mode flag follows the drain enable
    `BCCC_ASSERT_NOW(a_mode_flag, out_valid, out_mode == out_drain)

    // a new result only follows a sample taken into the input register and passed on to the result register
    `BCCC_ASSERT_NOW(a_result_origin, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind battery_cycle_charge_controller bccc_checker u_bccc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_step   (result.regulator_step),
    .out_charge (result.charge_enable),
    .out_drain  (result.drain_enable),
    .out_mode   (result.cycle_mode)
);
